>>> sv/indexed_shift_list_macros.svh
// assertion macros for the indexed shift list
// used by indexed_shift_list.sv; expects aclk and aresetn in scope
`ifndef INDEXED_SHIFT_LIST_MACROS_SVH
`define INDEXED_SHIFT_LIST_MACROS_SVH

// property that must hold in the same cycle as its trigger
`define ISL_ASSERT_NOW(label, trig, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |-> (prop)) \
        else $error("indexed_shift_list check failed");

// property that must hold in the cycle after its trigger
`define ISL_ASSERT_NEXT(label, trig, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (prop)) \
        else $error("indexed_shift_list check failed");

`endif

>>> sv/isl_pkg.sv
// shared constants, codes and types of the indexed shift list
// no dependencies; used by isl_cell.sv and indexed_shift_list.sv
package isl_pkg;

    // list geometry
    localparam int CAPACITY      = 64;
    localparam int ELEMENT_WIDTH = 32;

    // fixed field widths of the stream payload
    localparam int CMD_W     = 2;
    localparam int POS_W     = 6;
    localparam int IN_ELEM_W = 32;
    localparam int COUNT_W   = 7;
    localparam int STATUS_W  = 2;

    // derived widths
    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int STORE_W = (ELEMENT_WIDTH < IN_ELEM_W) ? ELEMENT_WIDTH : IN_ELEM_W;

    localparam int S_FIELDS_W = CMD_W + POS_W + IN_ELEM_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = IN_ELEM_W + COUNT_W + STATUS_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    // command codes
    localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd3;

    // status codes
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD_INDEX = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

    typedef logic [STORE_W-1:0] elem_t;
    typedef logic [CMP_W-1:0]   cmp_t;

    // broadcast control from the front end to every cell
    typedef struct packed {
        logic              upd;   // accepted and allowed request
        logic [CMD_W-1:0]  cmd;
        cmp_t              pos;
        cmp_t              fill;
        elem_t             value;
    } ctl_t;

endpackage

>>> sv/isl_cell.sv
// one storage cell of the indexed shift list
// depends on isl_pkg; instantiated in a row by indexed_shift_list
module isl_cell (
    input  logic           aclk,
    input  isl_pkg::cmp_t  idx,       // place of this cell in the row
    input  isl_pkg::ctl_t  ctl,
    input  isl_pkg::elem_t left_val,  // value of the cell below
    input  isl_pkg::elem_t right_val, // value of the cell above
    output isl_pkg::elem_t cur_val,
    output isl_pkg::elem_t rd_val     // own value when addressed, else zero
);

    isl_pkg::elem_t val_reg;
    isl_pkg::elem_t val_next;

    // next value from the shared request
    always_comb begin
        val_next = val_reg;
        if (ctl.upd) begin
            unique case (ctl.cmd)
                isl_pkg::CMD_APPEND: begin
                    if (idx == ctl.fill) val_next = ctl.value;
                end
                isl_pkg::CMD_INSERT: begin
                    if (idx == ctl.pos) val_next = ctl.value;
                    else if (idx > ctl.pos) val_next = left_val;
                end
                isl_pkg::CMD_DELETE: begin
                    if (idx >= ctl.pos) val_next = right_val;
                end
                isl_pkg::CMD_READ: begin
                    val_next = val_reg;
                end
                default: begin
                    val_next = val_reg;
                end
            endcase
        end
    end

    // element storage, no reset
    always_ff @(posedge aclk) begin
        val_reg <= val_next;
    end

    assign cur_val = val_reg;
    assign rd_val  = (idx == ctl.pos) ? val_reg : '0;

endmodule

>>> sv/indexed_shift_list.sv
// top level of the indexed shift list: request decode, fill count,
// row of isl_cell storage cells and the result register
// depends on isl_pkg, isl_cell and indexed_shift_list_macros.svh
//
// usage:
//   s_ channel carries one request per transaction: append, insert at
//   index, delete at index, or read at index. m_ channel returns exactly
//   one result per request: element read, element count and status.
//   The result is registered: an accepted request has its result on
//   m_tdata in the cycle after. Throughput is one request per cycle
//   while the receiver keeps up; every cell of the row updates in the
//   same cycle, so the next request sees the updated list.
//   Refused requests (index not below count, or list full) leave the
//   list untouched. Reset empties the list at once (count zero); cell
//   contents are not cleared and are never read before written.
//   While the receiver stalls, the result stays in the output register
//   and s_tready drops until it is taken; s_tready is high whenever the
//   output register is empty or being emptied in the same cycle.
//
`include "indexed_shift_list_macros.svh"

module indexed_shift_list (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // cmd [1:0], position [7:2], element_in [39:8]
    input  logic [isl_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // element_out [31:0], count [38:32], status [40:39], zero fill above
    output logic [isl_pkg::M_TDATA_W-1:0] m_tdata
);

    logic [isl_pkg::CNT_W-1:0]     fill_reg;
    logic [isl_pkg::CNT_W-1:0]     fill_next;
    logic                          m_valid_reg;
    logic                          m_valid_next;
    logic [isl_pkg::M_TDATA_W-1:0] m_data_reg;
    logic [isl_pkg::M_TDATA_W-1:0] m_data_next;

    logic                          accept;
    logic [isl_pkg::CMD_W-1:0]     in_cmd;
    logic [isl_pkg::POS_W-1:0]     in_pos;
    logic [isl_pkg::IN_ELEM_W-1:0] in_elem;
    isl_pkg::cmp_t                 pos_ext;
    isl_pkg::cmp_t                 fill_ext;
    logic                          full;
    logic [isl_pkg::STATUS_W-1:0]  status;
    isl_pkg::ctl_t                 ctl;
    isl_pkg::elem_t                rd_data;
    logic [isl_pkg::IN_ELEM_W-1:0] elem_out;

    isl_pkg::elem_t cur_vals [isl_pkg::CAPACITY];
    isl_pkg::elem_t left_vals [isl_pkg::CAPACITY];
    isl_pkg::elem_t right_vals [isl_pkg::CAPACITY];
    isl_pkg::elem_t rd_vals [isl_pkg::CAPACITY];

    // handshake
    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // field unpacking
    assign in_cmd   = s_tdata[isl_pkg::CMD_W-1:0];
    assign in_pos   = s_tdata[isl_pkg::CMD_W +: isl_pkg::POS_W];
    assign in_elem  = s_tdata[isl_pkg::CMD_W + isl_pkg::POS_W +: isl_pkg::IN_ELEM_W];
    assign pos_ext  = isl_pkg::CMP_W'(in_pos);
    assign fill_ext = isl_pkg::CMP_W'(fill_reg);
    assign full     = (fill_reg == isl_pkg::CNT_W'(isl_pkg::CAPACITY));

    // status; index check ahead of the full check for insert
    always_comb begin
        if (in_cmd == isl_pkg::CMD_APPEND) begin
            status = full ? isl_pkg::STATUS_FULL : isl_pkg::STATUS_OK;
        end else if (pos_ext >= fill_ext) begin
            status = isl_pkg::STATUS_BAD_INDEX;
        end else if (in_cmd == isl_pkg::CMD_INSERT && full) begin
            status = isl_pkg::STATUS_FULL;
        end else begin
            status = isl_pkg::STATUS_OK;
        end
    end

    // broadcast to the cell row
    always_comb begin
        ctl.upd   = accept && (status == isl_pkg::STATUS_OK);
        ctl.cmd   = in_cmd;
        ctl.pos   = pos_ext;
        ctl.fill  = fill_ext;
        ctl.value = isl_pkg::STORE_W'(in_elem);
    end

    // row of cells with neighbor links
    for (genvar i = 0; i < isl_pkg::CAPACITY; i++) begin : g_cell
        if (i == 0) begin : g_first
            assign left_vals[i] = '0;
        end else begin : g_mid_lo
            assign left_vals[i] = cur_vals[i-1];
        end
        if (i == isl_pkg::CAPACITY - 1) begin : g_last
            assign right_vals[i] = '0;
        end else begin : g_mid_hi
            assign right_vals[i] = cur_vals[i+1];
        end

        isl_cell u_cell (
            .aclk      (aclk),
            .idx       (isl_pkg::CMP_W'(i)),
            .ctl       (ctl),
            .left_val  (left_vals[i]),
            .right_val (right_vals[i]),
            .cur_val   (cur_vals[i]),
            .rd_val    (rd_vals[i])
        );
    end

    // read collect: at most one cell drives a nonzero value
    always_comb begin
        rd_data = '0;
        for (int i = 0; i < isl_pkg::CAPACITY; i++) begin
            rd_data = rd_data | rd_vals[i];
        end
    end

    assign elem_out = (ctl.upd && in_cmd == isl_pkg::CMD_READ)
                      ? isl_pkg::IN_ELEM_W'(rd_data) : '0;

    // fill count
    always_comb begin
        fill_next = fill_reg;
        if (ctl.upd) begin
            unique case (in_cmd)
                isl_pkg::CMD_APPEND: fill_next = fill_reg + isl_pkg::CNT_W'(1);
                isl_pkg::CMD_INSERT: fill_next = fill_reg + isl_pkg::CNT_W'(1);
                isl_pkg::CMD_DELETE: fill_next = fill_reg - isl_pkg::CNT_W'(1);
                isl_pkg::CMD_READ:   fill_next = fill_reg;
                default:             fill_next = fill_reg;
            endcase
        end
    end

    // result register
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (accept) begin
            m_valid_next = 1'b1;
            m_data_next  = isl_pkg::M_TDATA_W'({status,
                                                isl_pkg::COUNT_W'(fill_next),
                                                elem_out});
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            fill_reg    <= fill_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // checks
    `ISL_ASSERT_NOW(a_fill_bound, 1'b1, fill_reg <= isl_pkg::CNT_W'(isl_pkg::CAPACITY))
    `ISL_ASSERT_NOW(a_full_only_at_cap, accept && status == isl_pkg::STATUS_FULL, full)
    `ISL_ASSERT_NEXT(a_refused_keeps_fill, accept && status != isl_pkg::STATUS_OK,
                     $stable(fill_reg))
    `ISL_ASSERT_NEXT(a_append_grows, ctl.upd && in_cmd == isl_pkg::CMD_APPEND,
                     fill_reg == $past(fill_reg) + isl_pkg::CNT_W'(1))

endmodule
